>>> rtl/mcprm_pkg.sv
// shared types and constants of the multi-channel pulse rate meter
package mcprm_pkg;

  localparam int unsigned CHANNELS_DEF = 4;
  localparam int unsigned COUNT_W      = 15;
  localparam int unsigned RATE_W       = 16;
  localparam int unsigned CD_W         = 16;
  localparam int unsigned TIMER_W      = 16;
  localparam int unsigned CH_W         = 2;

  localparam logic [COUNT_W-1:0] COUNT_LIMIT  = 15'h7FFF;
  localparam logic [TIMER_W-1:0] WINDOW_RESET = 16'd500;

  typedef enum logic [1:0] {
    FUNC_PULSE = 2'd0,
    FUNC_TICK  = 2'd1,
    FUNC_LOAD  = 2'd2
  } func_t;

  typedef struct packed {
    logic [1:0]      func;
    logic [CH_W-1:0] channel;
    logic [CD_W-1:0] countdown_value;
  } in_word_t;

  typedef struct packed {
    logic [RATE_W-1:0] rate;
    logic [CD_W-1:0]   countdown_left;
    logic              countdown_done;
    logic              window_closed;
  } out_word_t;

endpackage

>>> rtl/mcprm_if.sv
// valid/ready channel interfaces for input and result words
interface mcprm_in_if;
  import mcprm_pkg::*;

  logic                valid;
  logic                ready;
  logic [1:0]          func;
  logic [CH_W-1:0]     channel;
  logic [CD_W-1:0]     countdown_value;

  modport source (output valid, output func, output channel, output countdown_value,
                  input ready);
  modport sink   (input valid, input func, input channel, input countdown_value,
                  output ready);
endinterface

interface mcprm_out_if;
  import mcprm_pkg::*;

  logic                valid;
  logic                ready;
  logic [RATE_W-1:0]   rate;
  logic [CD_W-1:0]     countdown_left;
  logic                countdown_done;
  logic                window_closed;

  modport source (output valid, output rate, output countdown_left,
                  output countdown_done, output window_closed, input ready);
  modport sink   (input valid, input rate, input countdown_left,
                  input countdown_done, input window_closed, output ready);
endinterface

>>> rtl/mcprm_core.sv
// per-channel counters, countdowns, window timer and status lookup
module mcprm_core #(
  parameter int unsigned CHANNELS = mcprm_pkg::CHANNELS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [mcprm_pkg::TIMER_W-1:0]    cfg_wr_data,
  input  logic                             fire,
  input  mcprm_pkg::in_word_t              word_in,
  output mcprm_pkg::out_word_t             word_out
);
  import mcprm_pkg::*;

  logic [COUNT_W-1:0] window_count_r   [CHANNELS];
  logic [COUNT_W-1:0] window_count_nxt [CHANNELS];
  logic [COUNT_W-1:0] previous_count_r   [CHANNELS];
  logic [COUNT_W-1:0] previous_count_nxt [CHANNELS];
  logic [RATE_W-1:0]  rate_store_r   [CHANNELS];
  logic [RATE_W-1:0]  rate_store_nxt [CHANNELS];
  logic [CD_W-1:0]    countdown_r   [CHANNELS];
  logic [CD_W-1:0]    countdown_nxt [CHANNELS];
  logic [TIMER_W-1:0] window_timer_r;
  logic [TIMER_W-1:0] window_timer_nxt;
  logic [TIMER_W-1:0] window_ticks_r;
  logic [TIMER_W-1:0] timer_inc;

  logic ch_valid;
  logic is_pulse;
  logic is_tick;
  logic is_load;
  logic closed;

  always_comb begin
    ch_valid = 32'(word_in.channel) < CHANNELS;
    is_pulse = 1'b0;
    is_tick  = 1'b0;
    is_load  = 1'b0;
    case (word_in.func)
      FUNC_PULSE: is_pulse = 1'b1;
      FUNC_TICK:  is_tick  = 1'b1;
      FUNC_LOAD:  is_load  = 1'b1;
      default:    ;
    endcase

    timer_inc = (window_timer_r < window_ticks_r) ? window_timer_r + 1'b1 : window_timer_r;
    closed    = is_tick && (timer_inc >= window_ticks_r);
    if (!is_tick) begin
      window_timer_nxt = window_timer_r;
    end else if (closed) begin
      window_timer_nxt = '0;
    end else begin
      window_timer_nxt = timer_inc;
    end

    word_out.rate           = '0;
    word_out.countdown_left = '0;
    word_out.countdown_done = 1'b0;
    word_out.window_closed  = closed;

    for (int c = 0; c < CHANNELS; c++) begin
      window_count_nxt[c]   = window_count_r[c];
      previous_count_nxt[c] = previous_count_r[c];
      rate_store_nxt[c]     = rate_store_r[c];
      countdown_nxt[c]      = countdown_r[c];
      if (closed) begin
        rate_store_nxt[c]     = RATE_W'(previous_count_r[c]) + RATE_W'(window_count_r[c]);
        previous_count_nxt[c] = window_count_r[c];
        window_count_nxt[c]   = '0;
      end
      if (ch_valid && 32'(word_in.channel) == c) begin
        if (is_pulse) begin
          if (window_count_r[c] < COUNT_LIMIT) begin
            window_count_nxt[c] = window_count_r[c] + 1'b1;
          end
          if (countdown_r[c] != '0) begin
            countdown_nxt[c] = countdown_r[c] - 1'b1;
          end
        end
        if (is_load) begin
          countdown_nxt[c] = word_in.countdown_value;
        end
        word_out.rate           = rate_store_nxt[c];
        word_out.countdown_left = countdown_nxt[c];
        word_out.countdown_done = (countdown_nxt[c] == '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CHANNELS; c++) begin
        window_count_r[c]   <= '0;
        previous_count_r[c] <= '0;
        rate_store_r[c]     <= '0;
        countdown_r[c]      <= '0;
      end
      window_timer_r <= '0;
      window_ticks_r <= WINDOW_RESET;
    end else begin
      if (cfg_wr_en) begin
        window_ticks_r <= cfg_wr_data;
      end
      if (fire) begin
        for (int c = 0; c < CHANNELS; c++) begin
          window_count_r[c]   <= window_count_nxt[c];
          previous_count_r[c] <= previous_count_nxt[c];
          rate_store_r[c]     <= rate_store_nxt[c];
          countdown_r[c]      <= countdown_nxt[c];
        end
        window_timer_r <= window_timer_nxt;
      end
    end
  end

endmodule

>>> rtl/multi_channel_pulse_rate_meter.sv
// top level of the multi-channel pulse rate meter
// Takes one word per clock while the result side is taking words and returns one
// result word per input word, in order. A word is captured into an input register,
// processed by the channel update logic and held in a result register; the
// pipeline stalls only while a result waits. Closing a window updates all channels
// in that single cycle. cfg_wr_en writes the window period (reset 500 ticks).
module multi_channel_pulse_rate_meter #(
  parameter int unsigned CHANNELS = mcprm_pkg::CHANNELS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [mcprm_pkg::TIMER_W-1:0] cfg_wr_data,
  mcprm_in_if.sink                      in_if,
  mcprm_out_if.source                   out_if
);
  import mcprm_pkg::*;

  logic      in_vld_r;
  logic      in_vld_nxt;
  in_word_t  in_word_r;
  logic      out_vld_r;
  logic      out_vld_nxt;
  out_word_t out_word_r;
  out_word_t result;
  logic      advance;
  logic      in_take;

  // stage moves when the result register is free or being emptied
  assign advance   = in_vld_r && (!out_vld_r || out_if.ready);
  assign in_if.ready = !in_vld_r || advance;
  assign in_take   = in_if.valid && in_if.ready;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_take) begin
      in_vld_nxt = 1'b1;
    end else if (advance) begin
      in_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_vld_r;
    if (advance) begin
      out_vld_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  mcprm_core #(
    .CHANNELS (CHANNELS)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fire        (advance),
    .word_in     (in_word_r),
    .word_out    (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_word_r.func            <= in_if.func;
      in_word_r.channel         <= in_if.channel;
      in_word_r.countdown_value <= in_if.countdown_value;
    end
    if (advance) begin
      out_word_r <= result;
    end
  end

  assign out_if.valid          = out_vld_r;
  assign out_if.rate           = out_word_r.rate;
  assign out_if.countdown_left = out_word_r.countdown_left;
  assign out_if.countdown_done = out_word_r.countdown_done;
  assign out_if.window_closed  = out_word_r.window_closed;

endmodule
